### rtl/core/iee_pkg.sv
package iee_pkg;

  localparam logic [1:0] CMD_NUM  = 2'd0;
  localparam logic [1:0] CMD_OP   = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_UNDER = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_tok;    // capture the accepted token
    logic push_num;    // push the token's number
    logic push_op;     // push the token's operator
    logic pop_op;      // pop the top operator into the reduce register
    logic rd_right;    // start a read of the top operand
    logic rd_left;     // start a read of the operand under the top
    logic pop_two;     // drop the two operands just read
    logic start_exec;  // start the arithmetic on left and right
    logic push_res;    // push the arithmetic result
    logic flag_under;  // record underflow
    logic load_out;    // move the result into the output register
    logic clear;       // empty both stacks and clear the error
  } iee_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       ops_empty;
    logic       nums_lt2;
    logic       nums_empty;
    logic       top_hi_prio;  // top operator ranks at or above the token's
    logic       exec_done;
    logic [1:0] tok_cmd;
  } iee_stat_t;

endpackage

### rtl/core/iee_if.sv
interface iee_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic signed [31:0] operand;
  logic [1:0]  op_code;
  modport source(output valid, output cmd, output operand, output op_code, input ready);
  modport sink(input valid, input cmd, input operand, input op_code, output ready);
endinterface

interface iee_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value;
  logic [1:0]  status;
  modport source(output valid, output value, output status, input ready);
  modport sink(input valid, input value, input status, output ready);
endinterface

### rtl/core/iee_divider.sv
module iee_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_r, quo_r[31]};
  assign trial   = shifted - {1'b0, den_r};

  // Restoring division on magnitudes, one quotient bit a cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? (32'd0 - dividend) : dividend;
      den_nxt  = divisor[31] ? (32'd0 - divisor) : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule

### rtl/core/iee_datapath.sv
module iee_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  iee_pkg::iee_cmd_t  cmd,
  output iee_pkg::iee_stat_t stat,
  input  logic [1:0]         tok_cmd_in,
  input  logic [31:0]        tok_num_in,
  input  logic [1:0]         tok_op_in,
  output logic [31:0]        res_value,
  output logic [1:0]         res_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [31:0] num_mem [STACK_DEPTH];
  logic [1:0]  op_mem  [STACK_DEPTH];

  logic [CW-1:0] ncnt_r, ncnt_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [1:0]    tcmd_r;
  logic [31:0]   tnum_r;
  logic [1:0]    top_r;
  logic [1:0]    rop_r;
  logic [31:0]   rd_q;
  logic [31:0]   left_r, right_r;
  logic [31:0]   alu_r;
  logic          rd_r_pend, rd_l_pend;
  logic          exec_busy_r, exec_done_r;
  logic [31:0]   out_val_r;
  logic [1:0]    out_st_r;
  logic          div_start, div_done;
  logic [31:0]   div_q;
  logic [AW-1:0] rd_addr;
  logic          npush, opush;
  logic [31:0]   npush_val;
  logic [1:0]    res_status_w;

  function automatic logic [1:0] first_err(input logic [1:0] cur, input logic [1:0] e);
    first_err = (cur == iee_pkg::ST_OK) ? e : cur;
  endfunction

  // Operand push: a number token or an arithmetic result.
  assign npush     = cmd.push_num || cmd.push_res;
  assign npush_val = cmd.push_res ? alu_r : tnum_r;
  assign opush     = cmd.push_op && (ocnt_r < DEPTH_C);

  always_comb begin
    rd_addr = AW'(ncnt_r - CW'(1));
    if (cmd.rd_left) rd_addr = AW'(ncnt_r - CW'(2));
  end

  always_ff @(posedge clk) begin
    if (npush && ncnt_r < DEPTH_C) num_mem[AW'(ncnt_r)] <= npush_val;
    if (opush) op_mem[AW'(ocnt_r)] <= tnum_r[1:0];
    rd_q <= num_mem[rd_addr];
  end

  // Operator under the top, registered so a pop can refill the top copy.
  logic [1:0] below_q;
  always_ff @(posedge clk) begin
    below_q <= op_mem[AW'(ocnt_r - CW'(2))];
  end

  always_comb begin
    ncnt_nxt = ncnt_r;
    ocnt_nxt = ocnt_r;
    err_nxt  = err_r;
    if (npush) begin
      if (ncnt_r < DEPTH_C) ncnt_nxt = ncnt_r + CW'(1);
      else err_nxt = first_err(err_r, iee_pkg::ST_OVER);
    end
    if (cmd.push_op) begin
      if (ocnt_r < DEPTH_C) ocnt_nxt = ocnt_r + CW'(1);
      else err_nxt = first_err(err_r, iee_pkg::ST_OVER);
    end
    if (cmd.pop_op)  ocnt_nxt = ocnt_r - CW'(1);
    if (cmd.pop_two) ncnt_nxt = ncnt_r - CW'(2);
    if (cmd.flag_under) err_nxt = first_err(err_r, iee_pkg::ST_UNDER);
    if (cmd.start_exec && rop_r == iee_pkg::OP_DIV && right_r == 32'd0)
      err_nxt = first_err(err_nxt, iee_pkg::ST_DIV0);
    if (cmd.clear) begin
      ncnt_nxt = '0;
      ocnt_nxt = '0;
      err_nxt  = iee_pkg::ST_OK;
    end
  end

  assign div_start = cmd.start_exec && rop_r == iee_pkg::OP_DIV && right_r != 32'd0;

  iee_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (left_r),
    .divisor  (right_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncnt_r      <= '0;
      ocnt_r      <= '0;
      err_r       <= iee_pkg::ST_OK;
      rd_r_pend   <= 1'b0;
      rd_l_pend   <= 1'b0;
      exec_busy_r <= 1'b0;
      exec_done_r <= 1'b0;
    end else begin
      ncnt_r    <= ncnt_nxt;
      ocnt_r    <= ocnt_nxt;
      err_r     <= err_nxt;
      rd_r_pend <= cmd.rd_right;
      rd_l_pend <= cmd.rd_left;
      if (cmd.start_exec) begin
        exec_busy_r <= (rop_r == iee_pkg::OP_DIV) && (right_r != 32'd0);
        exec_done_r <= !((rop_r == iee_pkg::OP_DIV) && (right_r != 32'd0));
      end else if (exec_busy_r && div_done) begin
        exec_busy_r <= 1'b0;
        exec_done_r <= 1'b1;
      end else begin
        exec_done_r <= 1'b0;
      end
    end
    if (cmd.load_tok) begin
      tcmd_r <= tok_cmd_in;
      tnum_r <= (tok_cmd_in == iee_pkg::CMD_OP) ? {tok_num_in[31:2], tok_op_in} : tok_num_in;
    end
    if (opush) top_r <= tnum_r[1:0];
    else if (cmd.pop_op) top_r <= below_q;
    if (cmd.pop_op) rop_r <= top_r;
    if (rd_r_pend) right_r <= rd_q;
    if (rd_l_pend) left_r  <= rd_q;
    if (cmd.start_exec) begin
      case (rop_r)
        iee_pkg::OP_ADD: alu_r <= left_r + right_r;
        iee_pkg::OP_SUB: alu_r <= left_r - right_r;
        iee_pkg::OP_MUL: alu_r <= left_r * right_r;
        default:         alu_r <= 32'd0;
      endcase
    end else if (exec_busy_r && div_done) begin
      alu_r <= div_q;
    end
    if (cmd.load_out) begin
      out_val_r <= (ncnt_r == '0) ? 32'd0 : rd_q;
      out_st_r  <= res_status_w;
    end
  end

  assign res_status_w = (ncnt_r == '0) ? first_err(err_r, iee_pkg::ST_UNDER) : err_r;

  assign stat.ops_empty   = (ocnt_r == '0);
  assign stat.nums_lt2    = (ncnt_r < CW'(2));
  assign stat.nums_empty  = (ncnt_r == '0);
  assign stat.top_hi_prio = top_r[1] || !tnum_r[1];
  assign stat.exec_done   = exec_done_r;
  assign stat.tok_cmd     = tcmd_r;

  assign res_value  = out_val_r;
  assign res_status = out_st_r;

endmodule

### rtl/core/iee_ctrl.sv
module iee_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  output logic               in_rdy,
  input  logic               out_busy,
  output logic               out_set,
  input  iee_pkg::iee_stat_t stat,
  output iee_pkg::iee_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_RDR   = 4'd4;
  localparam logic [3:0] S_RDL   = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_PUSHR = 4'd8;
  localparam logic [3:0] S_TOP   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_HOLD  = 4'd11;
  localparam logic [3:0] S_POPW  = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_set   = 1'b0;
    in_rdy    = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_tok = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.tok_cmd)
          iee_pkg::CMD_NUM: begin
            cmd.push_num = 1'b1;
            state_nxt    = S_IDLE;
          end
          iee_pkg::CMD_OP:  state_nxt = S_CHECK;
          iee_pkg::CMD_END: begin
            cmd.push_num = 1'b1;
            state_nxt    = S_CHECK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHECK: begin
        if (!stat.ops_empty &&
            (stat.tok_cmd == iee_pkg::CMD_END || stat.top_hi_prio)) begin
          state_nxt = S_POP;
        end else if (stat.tok_cmd == iee_pkg::CMD_END) begin
          cmd.rd_right = 1'b1;
          state_nxt    = S_TOP;
        end else begin
          cmd.push_op = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_POP: begin
        // The operator under the top is fetched in the cycle before the pop.
        state_nxt = S_POPW;
      end
      S_POPW: begin
        cmd.pop_op = 1'b1;
        if (stat.nums_lt2) begin
          cmd.flag_under = 1'b1;
          state_nxt      = S_CHECK;
        end else begin
          cmd.rd_right = 1'b1;
          state_nxt    = S_RDR;
        end
      end
      S_RDR: begin
        cmd.rd_left = 1'b1;
        state_nxt   = S_RDL;
      end
      S_RDL: begin
        cmd.pop_two = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        cmd.start_exec = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (stat.exec_done) state_nxt = S_PUSHR;
      end
      S_PUSHR: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_TOP: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          out_set      = 1'b1;
          state_nxt    = S_HOLD;
        end
      end
      S_HOLD: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/core/infix_expression_evaluator.sv
// Two-stack infix evaluator. Tokens enter one at a time on the in channel:
// a number, an operator, or a number that ends the expression; only the
// ending number yields a request on the out channel carrying the value and
// the first error seen (divide by zero, stack overflow, stack underflow).
// Each operator token first reduces the stacked operators that rank at or
// above it, and an ending number reduces them all. A reduction with too
// few operands records underflow; a division by a nonzero value waits on
// the one-bit-a-cycle divider. The output register lets the block take
// new tokens while a result waits; a second ending number then stalls
// until the waiting result is taken.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input logic  clk,
  input logic  rst_n,
  iee_in_if.sink    in_ch,
  iee_out_if.source out_ch
);

  iee_pkg::iee_cmd_t  cmd;
  iee_pkg::iee_stat_t stat;
  logic        in_rdy, out_set, in_fire;
  logic        out_valid_r;
  logic [31:0] res_value;
  logic [1:0]  res_status;

  assign in_fire     = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_rdy   (in_rdy),
    .out_busy (out_valid_r && !out_ch.ready),
    .out_set  (out_set),
    .stat     (stat),
    .cmd      (cmd)
  );

  iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .tok_cmd_in (in_ch.cmd),
    .tok_num_in (in_ch.operand),
    .tok_op_in  (in_ch.op_code),
    .res_value  (res_value),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_set) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = res_value;
  assign out_ch.status = res_status;

`ifndef SYNTHESIS
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_set |-> !(out_valid_r && !out_ch.ready))
    else $error("result overwritten while waiting");
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("result dropped while stalled");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_rdy)
    else $error("token accepted while busy");
`endif

endmodule

### tb/infix_expression_evaluator_tb.sv
module infix_expression_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int RAND_ITEMS  = 1800;
  localparam int IDLE_LIMIT  = 6000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] operand;
    logic [1:0]  op_code;
    bit          typed;
    logic [31:0] value;
    logic [1:0]  status;
  } token_row_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  iee_in_if  in_ch();
  iee_out_if out_ch();

  infix_expression_evaluator #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Evaluator state mirrored in the testbench.
  logic [31:0] operand_mirror [DEPTH];
  logic [1:0]  opr_stack [DEPTH];
  int          num_count;
  int          opr_count;
  logic [1:0]  first_error;

  result_t     results_due[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          tokens_sent;
  bit          long_hold_req;
  token_row_t  expr_tokens[$];

  function automatic void note_error(logic [1:0] code);
    if (first_error == iee_pkg::ST_OK) first_error = code;
  endfunction

  function automatic void push_number(logic [31:0] v);
    if (num_count >= DEPTH) begin
      note_error(iee_pkg::ST_OVER);
    end else begin
      operand_mirror[num_count] = v;
      num_count++;
    end
  endfunction

  function automatic logic [31:0] quotient_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic void reduce_top();
    logic [1:0]  op;
    logic [31:0] lhs, rhs, res;
    if (opr_count == 0) return;
    opr_count--;
    op = opr_stack[opr_count];
    if (num_count < 2) begin
      note_error(iee_pkg::ST_UNDER);
      return;
    end
    rhs = operand_mirror[num_count-1];
    lhs = operand_mirror[num_count-2];
    num_count -= 2;
    case (op)
      iee_pkg::OP_ADD: res = lhs + rhs;
      iee_pkg::OP_SUB: res = lhs - rhs;
      iee_pkg::OP_MUL: res = lhs * rhs;
      default: begin
        if (rhs == 0) begin
          note_error(iee_pkg::ST_DIV0);
          res = '0;
        end else begin
          res = quotient_trunc(lhs, rhs);
        end
      end
    endcase
    push_number(res);
  endfunction

  // Applies one token; returns 1 when the token ends an expression.
  function automatic bit evaluate_token(logic [1:0] cmd, logic [31:0] operand,
                                        logic [1:0] op, output result_t res);
    res.value = '0;
    res.status = iee_pkg::ST_OK;
    if (cmd == iee_pkg::CMD_NUM) begin
      push_number(operand);
      return 0;
    end
    if (cmd == iee_pkg::CMD_OP) begin
      while (opr_count > 0 &&
             (opr_stack[opr_count-1] >= iee_pkg::OP_MUL) >= (op >= iee_pkg::OP_MUL))
        reduce_top();
      if (opr_count >= DEPTH) begin
        note_error(iee_pkg::ST_OVER);
      end else begin
        opr_stack[opr_count] = op;
        opr_count++;
      end
      return 0;
    end
    if (cmd == iee_pkg::CMD_END) begin
      push_number(operand);
      while (opr_count > 0) reduce_top();
      if (num_count == 0) note_error(iee_pkg::ST_UNDER);
      else res.value = operand_mirror[num_count-1];
      res.status = first_error;
      num_count = 0;
      opr_count = 0;
      first_error = iee_pkg::ST_OK;
      return 1;
    end
    return 0;
  endfunction

  task automatic send_token(token_row_t t);
    result_t res;
    in_ch.valid = 1'b1;
    in_ch.cmd = t.cmd;
    in_ch.operand = t.operand;
    in_ch.op_code = t.op_code;
    do @(posedge clk); while (!in_ch.ready);
    tokens_sent++;
    if (evaluate_token(t.cmd, t.operand, t.op_code, res)) begin
      if (t.typed) begin
        res.value = t.value;
        res.status = t.status;
      end
      results_due.push_back(res);
    end
    @(negedge clk);
    if ($urandom_range(0, 99) >= 60) begin
      in_ch.valid = 1'b0;
      if ($urandom_range(0, 9) < 8) repeat ($urandom_range(0, 2)) @(negedge clk);
      else repeat ($urandom_range(10, 40)) @(negedge clk);
    end
  endtask

  function automatic token_row_t make_token(logic [1:0] cmd, logic [31:0] operand,
                                            logic [1:0] op);
    token_row_t t;
    t.cmd = cmd;
    t.operand = operand;
    t.op_code = op;
    t.typed = 0;
    t.value = '0;
    t.status = iee_pkg::ST_OK;
    return t;
  endfunction

  function automatic token_row_t typed_end(logic [31:0] operand, logic [31:0] v,
                                           logic [1:0] s);
    token_row_t t;
    t = make_token(iee_pkg::CMD_END, operand, iee_pkg::OP_ADD);
    t.typed = 1;
    t.value = v;
    t.status = s;
    return t;
  endfunction

  function automatic logic [31:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 32'($signed($urandom_range(0, 40)) - 20);
    if (r < 58) return 32'h0000_0000;
    if (r < 62) return 32'h7fff_ffff;
    if (r < 66) return 32'h8000_0000;
    if (r < 70) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // Builds one expression: mostly well formed, sometimes broken or overlong.
  task automatic build_expression();
    int n_ops, r, k;
    expr_tokens.delete();
    r = $urandom_range(0, 99);
    if (r < 3) begin
      repeat ($urandom_range(DEPTH - 2, DEPTH + 4))
        expr_tokens.push_back(make_token(iee_pkg::CMD_NUM, pick_number(), iee_pkg::OP_ADD));
      expr_tokens.push_back(make_token(iee_pkg::CMD_END, pick_number(), iee_pkg::OP_ADD));
      return;
    end
    if (r < 13) begin
      repeat ($urandom_range(1, 6))
        expr_tokens.push_back(make_token(2'($urandom_range(0, 3)), $urandom,
                                         2'($urandom_range(0, 3))));
      expr_tokens.push_back(make_token(iee_pkg::CMD_END, pick_number(), iee_pkg::OP_ADD));
      return;
    end
    n_ops = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 12);
    for (k = 0; k < n_ops; k++) begin
      if (!(r < 20 && $urandom_range(0, 3) == 0))
        expr_tokens.push_back(make_token(iee_pkg::CMD_NUM, pick_number(), iee_pkg::OP_ADD));
      expr_tokens.push_back(make_token(iee_pkg::CMD_OP, '0, 2'($urandom_range(0, 3))));
    end
    expr_tokens.push_back(make_token(iee_pkg::CMD_END, pick_number(), iee_pkg::OP_ADD));
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int run;
    bit held;
    held = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !held) begin
        held = 1;
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(0, 99) < 70);
      run = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 4) : $urandom_range(10, 50);
      repeat (run) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: value %0d status %0d", out_ch.value, out_ch.status);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (out_ch.value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), out_ch.value);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("infix_expression_evaluator_tb: errors");
      $finish;
    end
  end

  initial begin
    token_row_t directed[$];
    int k;
    bit paused;
    num_count = 0;
    opr_count = 0;
    first_error = iee_pkg::ST_OK;
    tokens_sent = 0;
    long_hold_req = 0;
    paused = 0;
    in_ch.valid = 1'b0;
    in_ch.cmd = iee_pkg::CMD_NUM;
    in_ch.operand = '0;
    in_ch.op_code = iee_pkg::OP_ADD;

    directed = '{
      typed_end(32'd5, 32'd5, iee_pkg::ST_OK),
      // Operator with a single operand underflows and keeps the number.
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_ADD),
      typed_end(32'd7, 32'd7, iee_pkg::ST_UNDER),
      make_token(iee_pkg::CMD_NUM, 32'h7fff_ffff, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_ADD),
      typed_end(32'd1, 32'h8000_0000, iee_pkg::ST_OK),
      make_token(iee_pkg::CMD_NUM, 32'h8000_0000, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_DIV),
      typed_end(32'hffff_ffff, 32'h8000_0000, iee_pkg::ST_OK),
      make_token(iee_pkg::CMD_NUM, 32'd9, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_DIV),
      typed_end(32'd0, 32'd0, iee_pkg::ST_DIV0),
      make_token(iee_pkg::CMD_NUM, 32'd2, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_NUM, 32'd3, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_MUL),
      make_token(iee_pkg::CMD_END, 32'd4, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_NUM, 32'hffff_fff9, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_DIV),
      make_token(iee_pkg::CMD_NUM, 32'd2, iee_pkg::OP_ADD),
      make_token(iee_pkg::CMD_OP, '0, iee_pkg::OP_SUB),
      make_token(iee_pkg::CMD_END, 32'd10, iee_pkg::OP_ADD),
      // The unused command code must leave the state alone.
      make_token(iee_pkg::CMD_RSVD, 32'hffff_ffff, iee_pkg::OP_DIV),
      typed_end(32'd1, 32'd1, iee_pkg::ST_OK)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (k = 0; k < directed.size(); k++) send_token(directed[k]);

    while (tokens_sent < RAND_ITEMS) begin
      if (tokens_sent > 300) long_hold_req = 1;
      if (tokens_sent > 900 && !paused) begin
        paused = 1;
        in_ch.valid = 1'b0;
        while (results_due.size() != 0) @(negedge clk);
      end
      build_expression();
      foreach (expr_tokens[i]) send_token(expr_tokens[i]);
    end

    in_ch.valid = 1'b0;
    @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_count == 0) begin
      $display("infix_expression_evaluator_tb: clean");
    end else begin
      $display("infix_expression_evaluator_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/iee_pkg.sv
rtl/core/iee_if.sv
rtl/core/iee_divider.sv
rtl/core/iee_datapath.sv
rtl/core/iee_ctrl.sv
rtl/core/infix_expression_evaluator.sv
tb/infix_expression_evaluator_tb.sv
